// File: rtl/imrht_pkg.sv
// Shared types and constants for the image map region hit test block.
// No dependencies; imported by the top level.
package imrht_pkg;

   localparam int MAX_REGIONS_DEF       = 64;
   localparam int MAX_POLY_VERTICES_DEF = 16;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int OP_W       = 2;
   localparam int RIDX_IN_W  = 6;
   localparam int VIDX_IN_W  = 4;
   localparam int KIND_W     = 3;
   localparam int VCNT_W     = 5;
   localparam int MKIND_W    = 2;
   localparam int RCOUNT_W   = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_REGION  = 2'd0;
   localparam logic [OP_W-1:0] OP_VERTEX  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

   localparam logic [KIND_W-1:0] KIND_POINT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RECT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POLY    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DEFAULT = 3'd5;

   localparam logic [MKIND_W-1:0] MATCH_HIT     = 2'd0;
   localparam logic [MKIND_W-1:0] MATCH_NEAREST = 2'd1;
   localparam logic [MKIND_W-1:0] MATCH_DEFAULT = 2'd2;
   localparam logic [MKIND_W-1:0] MATCH_NONE    = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_REGION_COUNT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_ENABLE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_REGION = 2'd2;

   typedef struct packed {
      logic [VCNT_W-1:0]         vcount;
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x0;
   } region_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

endpackage

// File: rtl/image_map_region_hit_test.sv
// Top level of the image map region hit test: region table, vertex store, query sequencer.
// Depends on imrht_pkg and imrht_ram.
//
// Usage:
//   req_ channel carries one item per handshake: a region write, a vertex
//   write or a query point. Writes give no result.
//   A query walks regions 0 .. region_count-1, capped at MAX_REGIONS,
//   through one shared 17x17 multiplier; the first rectangle, circle or
//   polygon hit ends the walk. A rectangle is compared directly, a point or
//   circle takes three products and a compare, a polygon reads its last vertex
//   and then each vertex, with two products per edge crossing the query row.
//   Then the nearest point, else the default region, else no match is returned.
//   req_tready is high only while the sequencer is idle.
//   rsp_ channel holds one result in an output register; a stalled
//   receiver stalls the finished query but not a following write.
//   csr_ port writes region_count, default_enable, default_region; write
//   only while idle.
//   Reset clears control state and the CSR registers; datapath registers
//   and table contents stay undefined until written.
module image_map_region_hit_test
   import imrht_pkg::*;
#(
   parameter int MAX_REGIONS       = MAX_REGIONS_DEF,
   parameter int MAX_POLY_VERTICES = MAX_POLY_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // op, region_index, vertex_index, shape_kind, vertex_total, x, y, x_far, y_far
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found, found_index, match_kind
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RIDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int RCNT_W  = $clog2(MAX_REGIONS + 1);
   localparam int VDEPTH  = MAX_REGIONS * MAX_POLY_VERTICES;
   localparam int VADDR_W = $clog2(VDEPTH);

   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_FETCH  = 18'h00002,
      ST_DECODE = 18'h00004,
      ST_MUL_A  = 18'h00008,
      ST_MUL_B  = 18'h00010,
      ST_MUL_C  = 18'h00020,
      ST_CMP    = 18'h00040,
      ST_PREQ   = 18'h00080,
      ST_PLATJ  = 18'h00100,
      ST_PEDGE  = 18'h00200,
      ST_PLHS   = 18'h00400,
      ST_PRHS   = 18'h00800,
      ST_PCMP   = 18'h01000,
      ST_PISSUE = 18'h02000,
      ST_FIN    = 18'h04000,
      ST_DFETCH = 18'h08000,
      ST_DDEC   = 18'h10000,
      ST_OUT    = 18'h20000
   } state_type;

   // input fields
   logic [OP_W-1:0]           req_op;
   logic [RIDX_IN_W-1:0]      req_region_index;
   logic [VIDX_IN_W-1:0]      req_vertex_index;
   logic [KIND_W-1:0]         req_shape_kind;
   logic [VCNT_W-1:0]         req_vertex_total;
   logic signed [COORD_W-1:0] req_x, req_y, req_x_far, req_y_far;

   assign req_op           = req_tdata[1:0];
   assign req_region_index = req_tdata[7:2];
   assign req_vertex_index = req_tdata[11:8];
   assign req_shape_kind   = req_tdata[14:12];
   assign req_vertex_total = req_tdata[19:15];
   assign req_x            = $signed(req_tdata[35:20]);
   assign req_y            = $signed(req_tdata[51:36]);
   assign req_x_far        = $signed(req_tdata[67:52]);
   assign req_y_far        = $signed(req_tdata[83:68]);

   // registers
   state_type                 state_ff, state_in;
   logic [RCOUNT_W-1:0]       rcount_ff, rcount_in;
   logic                      def_en_ff, def_en_in;
   logic [RIDX_IN_W-1:0]      def_reg_ff, def_reg_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [RCNT_W-1:0]         idx_ff, idx_in;
   logic signed [DIFF_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, rad_ff, rad_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic [VCNT_W-1:0]         nv_ff, nv_in, vi_ff, vi_in;
   logic signed [COORD_W-1:0] xi_ff, xi_in, yi_ff, yi_in, xj_ff, xj_in, yj_ff, yj_in;
   logic                      inside_ff, inside_in;
   logic                      have_ff, have_in;
   logic signed [ACC_W-1:0]   best_ff, best_in, acc_ff, acc_in;
   logic [RIDX_W-1:0]         best_idx_ff, best_idx_in, sel_ff, sel_in;
   logic [MKIND_W-1:0]        mkind_ff, mkind_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // memories
   region_type            reg_wdata, reg_rdata;
   logic [RIDX_W-1:0]     reg_raddr;
   logic                  reg_we;
   vertex_type            vtx_wdata, vtx_rdata;
   logic [VADDR_W-1:0]    vtx_waddr, vtx_raddr;
   logic                  vtx_we;
   logic [VCNT_W-1:0]     vtx_rsel;

   logic                  req_fire;
   logic [RCNT_W-1:0]     count;
   logic                  last;
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [DIFF_W-1:0] sum_x, sum_y, span_x;
   logic                  spans, left;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign reg_we = req_fire && (req_op == OP_REGION)
                   && (32'(req_region_index) < MAX_REGIONS);
   assign reg_wdata.vcount = (32'(req_vertex_total) > MAX_POLY_VERTICES)
                             ? VCNT_W'(MAX_POLY_VERTICES) : req_vertex_total;
   assign reg_wdata.kind = req_shape_kind;
   assign reg_wdata.x0   = req_x;
   assign reg_wdata.y0   = req_y;
   assign reg_wdata.x1   = req_x_far;
   assign reg_wdata.y1   = req_y_far;

   assign vtx_we = req_fire && (req_op == OP_VERTEX)
                   && (32'(req_region_index) < MAX_REGIONS)
                   && (32'(req_vertex_index) < MAX_POLY_VERTICES);
   assign vtx_waddr = VADDR_W'(VADDR_W'(req_region_index) * VADDR_W'(MAX_POLY_VERTICES)
                      + VADDR_W'(req_vertex_index));
   assign vtx_wdata.x = req_x;
   assign vtx_wdata.y = req_y;

   assign reg_raddr = (state_ff == ST_DFETCH) ? RIDX_W'(def_reg_ff) : idx_ff[RIDX_W-1:0];
   assign vtx_rsel  = (state_ff == ST_PREQ) ? (nv_ff - VCNT_W'(1)) : vi_ff;
   assign vtx_raddr = VADDR_W'(VADDR_W'(idx_ff[RIDX_W-1:0]) * VADDR_W'(MAX_POLY_VERTICES)
                      + VADDR_W'(vtx_rsel));

   imrht_ram #(.WIDTH($bits(region_type)), .DEPTH(MAX_REGIONS)) u_region_ram (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (req_region_index[RIDX_W-1:0]),
      .wr_data (reg_wdata),
      .rd_addr (reg_raddr),
      .rd_data (reg_rdata)
   );

   imrht_ram #(.WIDTH($bits(vertex_type)), .DEPTH(VDEPTH)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (vtx_waddr),
      .wr_data (vtx_wdata),
      .rd_addr (vtx_raddr),
      .rd_data (vtx_rdata)
   );

   assign count = (32'(rcount_ff) > MAX_REGIONS) ? RCNT_W'(MAX_REGIONS) : RCNT_W'(rcount_ff);
   assign last  = (idx_ff + RCNT_W'(1)) == count;

   assign sum_x  = DIFF_W'(reg_rdata.x0) + DIFF_W'(reg_rdata.x1);
   assign sum_y  = DIFF_W'(reg_rdata.y0) + DIFF_W'(reg_rdata.y1);
   assign span_x = DIFF_W'(reg_rdata.x1) - DIFF_W'(reg_rdata.x0);

   assign spans = (yi_ff > py_ff) != (yj_ff > py_ff);
   assign left  = (yj_ff > yi_ff) ? (acc_ff < ACC_W'(prod_ff)) : (acc_ff > ACC_W'(prod_ff));

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_A: begin
            mul_a = DIFF_W'(px_ff) - cx_ff;
            mul_b = DIFF_W'(px_ff) - cx_ff;
         end
         ST_MUL_B: begin
            mul_a = DIFF_W'(py_ff) - cy_ff;
            mul_b = DIFF_W'(py_ff) - cy_ff;
         end
         ST_MUL_C: begin
            mul_a = rad_ff;
            mul_b = rad_ff;
         end
         ST_PLHS: begin
            mul_a = DIFF_W'(px_ff) - DIFF_W'(xi_ff);
            mul_b = DIFF_W'(yj_ff) - DIFF_W'(yi_ff);
         end
         ST_PRHS: begin
            mul_a = DIFF_W'(xj_ff) - DIFF_W'(xi_ff);
            mul_b = DIFF_W'(py_ff) - DIFF_W'(yi_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in     = state_ff;
      rcount_in    = rcount_ff;
      def_en_in    = def_en_ff;
      def_reg_in   = def_reg_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      idx_in       = idx_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rad_in       = rad_ff;
      kind_in      = kind_ff;
      nv_in        = nv_ff;
      vi_in        = vi_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      xj_in        = xj_ff;
      yj_in        = yj_ff;
      inside_in    = inside_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      acc_in       = acc_ff;
      best_idx_in  = best_idx_ff;
      sel_in       = sel_ff;
      mkind_in     = mkind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_REGION_COUNT:   rcount_in  = csr_wdata[RCOUNT_W-1:0];
            CSR_DEFAULT_ENABLE: def_en_in  = csr_wdata[0];
            CSR_DEFAULT_REGION: def_reg_in = csr_wdata[RIDX_IN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_QUERY) begin
               px_in   = req_x;
               py_in   = req_y;
               idx_in  = '0;
               have_in = 1'b0;
               state_in = (count == '0) ? ST_FIN : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_DECODE;
         ST_DECODE: begin
            kind_in   = reg_rdata.kind;
            nv_in     = reg_rdata.vcount;
            vi_in     = '0;
            inside_in = 1'b0;
            if (reg_rdata.kind == KIND_CIRCLE) begin
               cx_in  = sum_x >>> 1;
               cy_in  = sum_y >>> 1;
               rad_in = span_x >>> 1;
            end else begin
               cx_in  = DIFF_W'(reg_rdata.x0);
               cy_in  = DIFF_W'(reg_rdata.y0);
               rad_in = '0;
            end
            case (reg_rdata.kind)
               KIND_POINT, KIND_CIRCLE: state_in = ST_MUL_A;
               KIND_RECT: begin
                  if (px_ff >= reg_rdata.x0 && px_ff <= reg_rdata.x1 &&
                      py_ff >= reg_rdata.y0 && py_ff <= reg_rdata.y1) begin
                     sel_in   = idx_ff[RIDX_W-1:0];
                     mkind_in = MATCH_HIT;
                     state_in = ST_OUT;
                  end else begin
                     idx_in   = idx_ff + RCNT_W'(1);
                     state_in = last ? ST_FIN : ST_FETCH;
                  end
               end
               KIND_POLY: begin
                  if (reg_rdata.vcount == '0) begin
                     idx_in   = idx_ff + RCNT_W'(1);
                     state_in = last ? ST_FIN : ST_FETCH;
                  end else begin
                     state_in = ST_PREQ;
                  end
               end
               default: begin
                  idx_in   = idx_ff + RCNT_W'(1);
                  state_in = last ? ST_FIN : ST_FETCH;
               end
            endcase
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: begin
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (kind_ff == KIND_CIRCLE && acc_ff <= ACC_W'(prod_ff)) begin
               sel_in   = idx_ff[RIDX_W-1:0];
               mkind_in = MATCH_HIT;
               state_in = ST_OUT;
            end else begin
               if (kind_ff == KIND_POINT && (!have_ff || acc_ff < best_ff)) begin
                  best_in     = acc_ff;
                  best_idx_in = idx_ff[RIDX_W-1:0];
               end
               if (kind_ff == KIND_POINT) begin
                  have_in = 1'b1;
               end
               idx_in   = idx_ff + RCNT_W'(1);
               state_in = last ? ST_FIN : ST_FETCH;
            end
         end
         ST_PREQ: state_in = ST_PLATJ;
         ST_PLATJ: begin
            xj_in    = vtx_rdata.x;
            yj_in    = vtx_rdata.y;
            state_in = ST_PEDGE;
         end
         ST_PEDGE: begin
            xi_in    = vtx_rdata.x;
            yi_in    = vtx_rdata.y;
            state_in = ST_PLHS;
         end
         ST_PLHS: begin
            if (spans) begin
               state_in = ST_PRHS;
            end else begin
               xj_in = xi_ff;
               yj_in = yi_ff;
               vi_in = vi_ff + VCNT_W'(1);
               if (vi_ff + VCNT_W'(1) == nv_ff) begin
                  if (inside_ff) begin
                     sel_in   = idx_ff[RIDX_W-1:0];
                     mkind_in = MATCH_HIT;
                     state_in = ST_OUT;
                  end else begin
                     idx_in   = idx_ff + RCNT_W'(1);
                     state_in = last ? ST_FIN : ST_FETCH;
                  end
               end else begin
                  state_in = ST_PISSUE;
               end
            end
         end
         ST_PRHS: begin
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            inside_in = inside_ff ^ left;
            xj_in     = xi_ff;
            yj_in     = yi_ff;
            vi_in     = vi_ff + VCNT_W'(1);
            if (vi_ff + VCNT_W'(1) == nv_ff) begin
               if (inside_ff ^ left) begin
                  sel_in   = idx_ff[RIDX_W-1:0];
                  mkind_in = MATCH_HIT;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff + RCNT_W'(1);
                  state_in = last ? ST_FIN : ST_FETCH;
               end
            end else begin
               state_in = ST_PISSUE;
            end
         end
         ST_PISSUE: state_in = ST_PEDGE;
         ST_FIN: begin
            if (have_ff) begin
               sel_in   = best_idx_ff;
               mkind_in = MATCH_NEAREST;
               state_in = ST_OUT;
            end else if (def_en_ff && 32'(def_reg_ff) < MAX_REGIONS) begin
               state_in = ST_DFETCH;
            end else begin
               sel_in   = '0;
               mkind_in = MATCH_NONE;
               state_in = ST_OUT;
            end
         end
         ST_DFETCH: state_in = ST_DDEC;
         ST_DDEC: begin
            if (reg_rdata.kind == KIND_DEFAULT) begin
               sel_in   = RIDX_W'(def_reg_ff);
               mkind_in = MATCH_DEFAULT;
            end else begin
               sel_in   = '0;
               mkind_in = MATCH_NONE;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[0]   = (mkind_ff != MATCH_NONE);
               rsp_data_in[6:1] = (mkind_ff == MATCH_NONE) ? '0 : RIDX_IN_W'(sel_ff);
               rsp_data_in[8:7] = mkind_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rcount_ff    <= '0;
         def_en_ff    <= 1'b0;
         def_reg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         inside_ff    <= 1'b0;
         idx_ff       <= '0;
         vi_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rcount_ff    <= rcount_in;
         def_en_ff    <= def_en_in;
         def_reg_ff   <= def_reg_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         inside_ff    <= inside_in;
         idx_ff       <= idx_in;
         vi_ff        <= vi_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rad_ff      <= rad_in;
      kind_ff     <= kind_in;
      nv_ff       <= nv_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      xj_ff       <= xj_in;
      yj_ff       <= yj_in;
      best_ff     <= best_in;
      acc_ff      <= acc_in;
      best_idx_ff <= best_idx_in;
      sel_ff      <= sel_in;
      mkind_ff    <= mkind_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/imrht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imrht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
